/* rtl/gpcg_pkg.sv */
// Shared types and constants for the gradient pixel colour generator.
// No dependencies; imported by every module of the block.
`default_nettype none

package gpcg_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int DIM_W          = 13;
    localparam int CH_W           = 8;
    localparam int NCH            = 3;
    localparam int QBITS          = 8;
    localparam int NUM_W          = 21;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 32;

    localparam logic [1:0] MODE_SOLID = 2'd0;
    localparam logic [1:0] MODE_VERT  = 2'd1;
    localparam logic [1:0] MODE_HORZ  = 2'd2;
    localparam logic [1:0] MODE_RAD   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_FILL_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_COLOR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_COLOR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SOLID_RGBA  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCR_WIDTH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCR_HEIGHT  = 3'd5;

    localparam logic [1:0]       RST_FILL_MODE   = MODE_VERT;
    localparam logic [23:0]      RST_START_COLOR = 24'h2896E6;
    localparam logic [23:0]      RST_END_COLOR   = 24'h50B4FF;
    localparam logic [31:0]      RST_SOLID_RGBA  = 32'h2896E6FF;
    localparam logic [DIM_W-1:0] RST_SCR_WIDTH   = 13'd640;
    localparam logic [DIM_W-1:0] RST_SCR_HEIGHT  = 13'd480;

    localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;

    typedef struct packed {
        logic [1:0]       mode;
        logic [23:0]      start_color;
        logic [23:0]      end_color;
        logic [31:0]      solid_rgba;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } t_cfg;

    // one slot of the divider chain: numerators become remainders as they pass
    typedef struct packed {
        logic                           vld;
        logic [DIM_W-1:0]               den;
        logic [NCH-1:0][NUM_W-1:0]      rem;
        logic [NCH-1:0][QBITS-1:0]      quo;
    } t_div_bus;

endpackage

`default_nettype wire

/* rtl/gpcg_front.sv */
// Front end: gradient position and length, clamp, and per-channel blend numerators.
// Four register stages; depends on gpcg_pkg.
`default_nettype none

module gpcg_front #(
    parameter int COORD_BITS = gpcg_pkg::COORD_BITS_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_accept,
    input  wire [COORD_BITS-1:0]   i_pix_x,
    input  wire [COORD_BITS-1:0]   i_pix_y,
    input  gpcg_pkg::t_cfg         i_cfg,
    output gpcg_pkg::t_div_bus     o_bus
);
    import gpcg_pkg::*;

    localparam int CW = (COORD_BITS > DIM_W - 1) ? COORD_BITS : DIM_W - 1;
    localparam int NW = CW + 2;

    // stage 1: axis distances and gradient length
    logic              r1_vld;
    logic              r1_rad;
    logic [CW-1:0]     r1_a;
    logic [CW-1:0]     r1_b;
    logic [DIM_W-1:0]  r1_d;
    logic              n1_rad;
    logic [CW-1:0]     n1_a;
    logic [CW-1:0]     n1_b;
    logic [DIM_W-1:0]  n1_d;

    logic [DIM_W-2:0]  cx;
    logic [DIM_W-2:0]  cy;
    logic [CW-1:0]     xe;
    logic [CW-1:0]     ye;
    logic [CW-1:0]     dx;
    logic [CW-1:0]     dy;

    always_comb begin
        cx = i_cfg.width[DIM_W-1:1];
        cy = i_cfg.height[DIM_W-1:1];
        xe = CW'(i_pix_x);
        ye = CW'(i_pix_y);
        dx = (xe >= CW'(cx)) ? xe - CW'(cx) : CW'(cx) - xe;
        dy = (ye >= CW'(cy)) ? ye - CW'(cy) : CW'(cy) - ye;
        n1_rad = 1'b0;
        n1_a   = '0;
        n1_b   = '0;
        n1_d   = '0;
        unique case (i_cfg.mode)
            MODE_SOLID: begin
                n1_d = '0;
            end
            MODE_VERT: begin
                n1_a = ye;
                n1_d = i_cfg.height;
            end
            MODE_HORZ: begin
                n1_a = xe;
                n1_d = i_cfg.width;
            end
            MODE_RAD: begin
                n1_rad = 1'b1;
                n1_a   = dx;
                n1_b   = dy;
                n1_d   = {((cx > cy) ? cx : cy), 1'b0};
            end
            default: begin
                n1_d = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_rad <= n1_rad;
        r1_a   <= n1_a;
        r1_b   <= n1_b;
        r1_d   <= n1_d;
    end

    // stage 2: octagonal distance, clamp; zero length blends with n=0, d=1
    logic              r2_vld;
    logic [DIM_W-1:0]  r2_n;
    logic [DIM_W-1:0]  r2_d;
    logic [DIM_W-1:0]  n2_n;
    logic [DIM_W-1:0]  n2_d;
    logic [CW-1:0]     hi;
    logic [CW-1:0]     lo;
    logic [NW-1:0]     nraw;

    always_comb begin
        hi   = (r1_a > r1_b) ? r1_a : r1_b;
        lo   = (r1_a > r1_b) ? r1_b : r1_a;
        nraw = r1_rad ? ({1'b0, hi, 1'b0} + NW'(lo)) : NW'(r1_a);
        n2_n = (nraw > NW'(r1_d)) ? r1_d : nraw[DIM_W-1:0];
        n2_d = r1_d;
        if (r1_d == '0) begin
            n2_n = '0;
            n2_d = DIM_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_n <= n2_n;
        r2_d <= n2_d;
    end

    // stage 3: products
    logic                       r3_vld;
    logic [DIM_W-1:0]           r3_d;
    logic [NCH-1:0][NUM_W-1:0]  r3_ps;
    logic [NCH-1:0][NUM_W-1:0]  r3_pe;
    logic [NCH-1:0][NUM_W-1:0]  n3_ps;
    logic [NCH-1:0][NUM_W-1:0]  n3_pe;
    logic [NCH-1:0][CH_W-1:0]   s_ch;
    logic [NCH-1:0][CH_W-1:0]   e_ch;
    logic [DIM_W-1:0]           dmn;

    always_comb begin
        dmn = r2_d - r2_n;
        for (int c = 0; c < NCH; c++) begin
            s_ch[c] = (i_cfg.mode == MODE_SOLID) ? i_cfg.solid_rgba[(NCH-c)*CH_W +: CH_W]
                                                 : i_cfg.start_color[(NCH-1-c)*CH_W +: CH_W];
            e_ch[c] = i_cfg.end_color[(NCH-1-c)*CH_W +: CH_W];
            n3_ps[c] = NUM_W'(s_ch[c]) * NUM_W'(dmn);
            n3_pe[c] = NUM_W'(e_ch[c]) * NUM_W'(r2_n);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_d  <= r2_d;
        r3_ps <= n3_ps;
        r3_pe <= n3_pe;
    end

    // stage 4: numerators into the divider chain
    logic                       r4_vld;
    logic [DIM_W-1:0]           r4_d;
    logic [NCH-1:0][NUM_W-1:0]  r4_num;
    logic [NCH-1:0][NUM_W-1:0]  n4_num;

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            n4_num[c] = r3_ps[c] + r3_pe[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_d   <= r3_d;
        r4_num <= n4_num;
    end

    always_comb begin
        o_bus.vld = r4_vld;
        o_bus.den = r4_d;
        o_bus.rem = r4_num;
        o_bus.quo = '0;
    end

endmodule

`default_nettype wire

/* rtl/gpcg_div_cell.sv */
// One restoring-division cell: decides one quotient bit for all three channels.
// Depends on gpcg_pkg.
`default_nettype none

module gpcg_div_cell #(
    parameter int BIT = 0
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  gpcg_pkg::t_div_bus     i_bus,
    output gpcg_pkg::t_div_bus     o_bus
);
    import gpcg_pkg::*;

    logic                       r_vld;
    logic [DIM_W-1:0]           r_den;
    logic [NCH-1:0][NUM_W-1:0]  r_rem;
    logic [NCH-1:0][QBITS-1:0]  r_quo;
    logic [NCH-1:0][NUM_W-1:0]  n_rem;
    logic [NCH-1:0][QBITS-1:0]  n_quo;
    logic [NUM_W-1:0]           sub;

    always_comb begin
        sub   = NUM_W'(i_bus.den) << BIT;
        n_rem = i_bus.rem;
        n_quo = i_bus.quo;
        for (int c = 0; c < NCH; c++) begin
            if (i_bus.rem[c] >= sub) begin
                n_rem[c]      = i_bus.rem[c] - sub;
                n_quo[c][BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_bus.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_den <= i_bus.den;
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    always_comb begin
        o_bus.vld = r_vld;
        o_bus.den = r_den;
        o_bus.rem = r_rem;
        o_bus.quo = r_quo;
    end

endmodule

`default_nettype wire

/* rtl/gradient_pixel_color_generator.sv */
// Top level: configuration registers, front end, divider cell chain, result register.
// Depends on gpcg_pkg, gpcg_front, gpcg_div_cell.
//
//  channel   signals                                       direction  transfer
//  pixel     start, busy, i_pix_x, i_pix_y                 in         start & !busy
//  result    o_strobe, o_red, o_green, o_blue, o_alpha      out        o_strobe
//  config    i_cfg_valid, o_cfg_ready, i_cfg_index/data    in         valid & ready
//
// One pixel per cycle outside reset; from transfer to result strobe a pixel passes four front stages,
// eight division cells (one quotient bit each) and one result register.
// busy is high only during reset; results cannot be held off.
// Reset (synchronous, active low) empties the pipe and loads the register defaults.
`default_nettype none

module gradient_pixel_color_generator #(
    parameter int COORD_BITS = gpcg_pkg::COORD_BITS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               start,
    output logic                              busy,
    input  wire [COORD_BITS-1:0]              i_pix_x,
    input  wire [COORD_BITS-1:0]              i_pix_y,
    output logic                              o_strobe,
    output logic [gpcg_pkg::CH_W-1:0]         o_red,
    output logic [gpcg_pkg::CH_W-1:0]         o_green,
    output logic [gpcg_pkg::CH_W-1:0]         o_blue,
    output logic [gpcg_pkg::CH_W-1:0]         o_alpha,
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire [gpcg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire [gpcg_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import gpcg_pkg::*;

    t_cfg      r_cfg;
    logic      accept;
    logic      cfg_wr;

    assign busy        = ~i_rst_n;
    assign o_cfg_ready = i_rst_n;
    assign accept      = start & ~busy;
    assign cfg_wr      = i_cfg_valid & o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode        <= RST_FILL_MODE;
            r_cfg.start_color <= RST_START_COLOR;
            r_cfg.end_color   <= RST_END_COLOR;
            r_cfg.solid_rgba  <= RST_SOLID_RGBA;
            r_cfg.width       <= RST_SCR_WIDTH;
            r_cfg.height      <= RST_SCR_HEIGHT;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                CFG_FILL_MODE:   r_cfg.mode        <= i_cfg_data[1:0];
                CFG_START_COLOR: r_cfg.start_color <= i_cfg_data[23:0];
                CFG_END_COLOR:   r_cfg.end_color   <= i_cfg_data[23:0];
                CFG_SOLID_RGBA:  r_cfg.solid_rgba  <= i_cfg_data;
                CFG_SCR_WIDTH:   r_cfg.width       <= i_cfg_data[DIM_W-1:0];
                CFG_SCR_HEIGHT:  r_cfg.height      <= i_cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    t_div_bus chain [0:QBITS];

    gpcg_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_pix_x  (i_pix_x),
        .i_pix_y  (i_pix_y),
        .i_cfg    (r_cfg),
        .o_bus    (chain[0])
    );

    for (genvar g = 0; g < QBITS; g++) begin : g_cell
        gpcg_div_cell #(
            .BIT (QBITS - 1 - g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bus   (chain[g]),
            .o_bus   (chain[g+1])
        );
    end

    logic             r_strobe;
    logic [CH_W-1:0]  r_red;
    logic [CH_W-1:0]  r_green;
    logic [CH_W-1:0]  r_blue;
    logic [CH_W-1:0]  r_alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= chain[QBITS].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_red   <= chain[QBITS].quo[0];
        r_green <= chain[QBITS].quo[1];
        r_blue  <= chain[QBITS].quo[2];
        r_alpha <= (r_cfg.mode == MODE_SOLID) ? r_cfg.solid_rgba[CH_W-1:0] : ALPHA_OPAQUE;
    end

    assign o_strobe = r_strobe;
    assign o_red    = r_red;
    assign o_green  = r_green;
    assign o_blue   = r_blue;
    assign o_alpha  = r_alpha;

    // the front end never hands the chain a zero divisor
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        chain[0].vld |-> chain[0].den != '0)
        else $error("zero divisor entered the divider chain");

    // after the last cell every remainder is below the divisor
    a_rem_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        chain[QBITS].vld |-> (chain[QBITS].rem[0] < NUM_W'(chain[QBITS].den))
                          && (chain[QBITS].rem[1] < NUM_W'(chain[QBITS].den))
                          && (chain[QBITS].rem[2] < NUM_W'(chain[QBITS].den)))
        else $error("division remainder not reduced");

    // the result strobe follows the last cell in the next cycle
    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        chain[QBITS].vld |=> o_strobe)
        else $error("result strobe lost");

endmodule

`default_nettype wire
